FILE: hw/rtl/button_debounce_long_press_core_assert.svh
// Assertion macros for the button debouncer core.
// BDLP_ASSERT runs on i_clk and is disabled while reset is asserted.
// BDLP_ASSERT_ANY runs on i_clk at every edge, reset included.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

`ifndef SYNTH

`define BDLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define BDLP_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define BDLP_ASSERT(lbl, prop, msg)

`define BDLP_ASSERT_ANY(lbl, prop, msg)

`endif

`endif

FILE: hw/rtl/bdlp_pkg.sv
package bdlp_pkg;

    // buttons handled, and the fixed width of the payload fields
    localparam int NUM_BUTTONS = 3;
    localparam int FIELD_W     = 3;
    localparam int LANE_W      = (NUM_BUTTONS > FIELD_W) ? NUM_BUTTONS : FIELD_W;

    localparam int COUNT_W = 8;
    localparam int TIMER_W = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register reset values
    localparam logic [COUNT_W-1:0] CEILING_RST   = 8'd200;
    localparam logic [COUNT_W-1:0] PRESS_TH_RST  = 8'd150;
    localparam logic [COUNT_W-1:0] REL_TH_RST    = 8'd40;
    localparam logic [TIMER_W-1:0] HOLD_DLY_RST  = 16'd500;
    localparam logic [TIMER_W-1:0] REPEAT_PR_RST = 16'd100;

    // register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_COUNT_CEILING     = 3'd0,
        REG_PRESS_THRESHOLD   = 3'd1,
        REG_RELEASE_THRESHOLD = 3'd2,
        REG_HOLD_DELAY        = 3'd3,
        REG_REPEAT_PERIOD     = 3'd4
    } t_reg_idx;

    typedef enum logic {
        CMD_SAMPLE   = 1'b0,
        CMD_EVALUATE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] count_ceiling;
        logic [COUNT_W-1:0] press_threshold;
        logic [COUNT_W-1:0] release_threshold;
        logic [TIMER_W-1:0] hold_delay;
        logic [TIMER_W-1:0] repeat_period;
    } t_cfg;

    // one lane's outcome for the current transaction
    typedef struct packed {
        logic pressed;
        logic press_ev;
        logic rel_ev;
        logic long_ev;
    } t_lane_res;

    // all lanes gathered for the merge stage
    typedef struct packed {
        logic [LANE_W-1:0] pressed;
        logic [LANE_W-1:0] press_ev;
        logic [LANE_W-1:0] rel_ev;
        logic [LANE_W-1:0] long_ev;
    } t_ev_vec;

endpackage

FILE: hw/rtl/bdlp_cfg.sv
module bdlp_cfg
    import bdlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_ceiling     <= CEILING_RST;
            r_cfg.press_threshold   <= PRESS_TH_RST;
            r_cfg.release_threshold <= REL_TH_RST;
            r_cfg.hold_delay        <= HOLD_DLY_RST;
            r_cfg.repeat_period     <= REPEAT_PR_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_COUNT_CEILING:     r_cfg.count_ceiling     <= pwdata[COUNT_W-1:0];
                REG_PRESS_THRESHOLD:   r_cfg.press_threshold   <= pwdata[COUNT_W-1:0];
                REG_RELEASE_THRESHOLD: r_cfg.release_threshold <= pwdata[COUNT_W-1:0];
                REG_HOLD_DELAY:        r_cfg.hold_delay        <= pwdata[TIMER_W-1:0];
                REG_REPEAT_PERIOD:     r_cfg.repeat_period     <= pwdata[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_COUNT_CEILING:     prdata = DATA_W'(r_cfg.count_ceiling);
            REG_PRESS_THRESHOLD:   prdata = DATA_W'(r_cfg.press_threshold);
            REG_RELEASE_THRESHOLD: prdata = DATA_W'(r_cfg.release_threshold);
            REG_HOLD_DELAY:        prdata = DATA_W'(r_cfg.hold_delay);
            REG_REPEAT_PERIOD:     prdata = DATA_W'(r_cfg.repeat_period);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/bdlp_lane.sv
module bdlp_lane
    import bdlp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_cmd      i_command,
    input  logic      i_pin,
    input  t_cfg      i_cfg,
    output t_lane_res o_res
);

    logic [COUNT_W-1:0] r_level, n_level;
    logic               r_pressed, n_pressed;
    logic [TIMER_W-1:0] r_hold, n_hold;
    logic [TIMER_W-1:0] r_repeat, n_repeat;
    logic               w_target;

    // one button: integrate on sample, decide and time on evaluate
    always_comb begin
        n_level   = r_level;
        n_pressed = r_pressed;
        n_hold    = r_hold;
        n_repeat  = r_repeat;
        w_target  = r_pressed;
        o_res     = '0;
        case (i_command)
            CMD_SAMPLE: begin
                if (i_pin && (r_level < i_cfg.count_ceiling)) begin
                    n_level = r_level + 1'b1;
                end else if (!i_pin && (r_level != '0)) begin
                    n_level = r_level - 1'b1;
                end
            end
            CMD_EVALUATE: begin
                // hysteresis, release wins when both thresholds hit
                if (r_level > i_cfg.press_threshold) begin
                    w_target = 1'b1;
                end
                if (r_level < i_cfg.release_threshold) begin
                    w_target = 1'b0;
                end
                if (w_target != r_pressed) begin
                    n_pressed = w_target;
                    if (w_target) begin
                        o_res.press_ev = 1'b1;
                    end else begin
                        o_res.rel_ev = 1'b1;
                        n_repeat     = '0;
                        n_hold       = i_cfg.hold_delay;
                    end
                end else if (r_pressed) begin
                    // hold delay first, then auto-repeat
                    if (r_hold != '0) begin
                        n_hold = r_hold - 1'b1;
                    end else if (r_repeat != '0) begin
                        n_repeat = r_repeat - 1'b1;
                    end else begin
                        o_res.long_ev = 1'b1;
                        n_repeat      = i_cfg.repeat_period;
                    end
                end
            end
            default: ;
        endcase
        o_res.pressed = n_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_pressed <= 1'b0;
            r_hold    <= HOLD_DLY_RST;
            r_repeat  <= '0;
        end else if (i_fire) begin
            r_level   <= n_level;
            r_pressed <= n_pressed;
            r_hold    <= n_hold;
            r_repeat  <= n_repeat;
        end
    end

endmodule

FILE: hw/rtl/bdlp_merge.sv
module bdlp_merge
    import bdlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  t_ev_vec            i_ev,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [FIELD_W-1:0] o_pressed_mask,
    output logic [FIELD_W-1:0] o_press_events,
    output logic [FIELD_W-1:0] o_release_events,
    output logic [FIELD_W-1:0] o_long_press_events
);

    logic               r_valid, n_valid;
    logic [FIELD_W-1:0] r_pressed, r_press, r_rel, r_long;

    // output register holds until taken, reloads in the same cycle it drains
    always_comb begin
        n_valid = r_valid && i_out_stall;
        if (i_fire) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // combine lane bits into the result fields
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_pressed <= i_ev.pressed[FIELD_W-1:0];
            r_press   <= i_ev.press_ev[FIELD_W-1:0];
            r_rel     <= i_ev.rel_ev[FIELD_W-1:0];
            r_long    <= i_ev.long_ev[FIELD_W-1:0];
        end
    end

    assign o_out_valid         = r_valid;
    assign o_pressed_mask      = r_pressed;
    assign o_press_events      = r_press;
    assign o_release_events    = r_rel;
    assign o_long_press_events = r_long;

endmodule

FILE: hw/rtl/button_debounce_long_press_core.sv
// Results: a result is presented in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the input side is not stalled; each button lane updates its
// counter and countdowns in the accept cycle, and a single output register feeds the result side.
// Reset (i_rst_n low, synchronous): counters and pressed states clear, hold countdowns
// load 500, repeat countdowns clear, registers return to their defaults.
`include "button_debounce_long_press_core_assert.svh"

module button_debounce_long_press_core
    import bdlp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic [FIELD_W-1:0] i_pin_levels,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FIELD_W-1:0] o_pressed_mask,
    output logic [FIELD_W-1:0] o_press_events,
    output logic [FIELD_W-1:0] o_release_events,
    output logic [FIELD_W-1:0] o_long_press_events,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    t_cfg              w_cfg;
    t_ev_vec           w_ev;
    t_cmd              w_cmd;
    logic [LANE_W-1:0] w_pins;
    logic              w_fire;
    logic              r_run;

    // hold off the input side until out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign o_in_stall = !r_run || (o_out_valid && i_out_stall);
    assign w_fire     = i_in_valid && !o_in_stall;
    assign w_cmd      = t_cmd'(i_command);
    assign w_pins     = LANE_W'(i_pin_levels);

    bdlp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // one lane per button, unused positions read as idle
    for (genvar b = 0; b < LANE_W; b++) begin : g_lane
        if (b < NUM_BUTTONS) begin : g_btn
            t_lane_res w_res;

            bdlp_lane u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_fire    (w_fire),
                .i_command (w_cmd),
                .i_pin     (w_pins[b]),
                .i_cfg     (w_cfg),
                .o_res     (w_res)
            );

            assign w_ev.pressed[b]  = w_res.pressed;
            assign w_ev.press_ev[b] = w_res.press_ev;
            assign w_ev.rel_ev[b]   = w_res.rel_ev;
            assign w_ev.long_ev[b]  = w_res.long_ev;
        end else begin : g_pad
            assign w_ev.pressed[b]  = 1'b0;
            assign w_ev.press_ev[b] = 1'b0;
            assign w_ev.rel_ev[b]   = 1'b0;
            assign w_ev.long_ev[b]  = 1'b0;
        end
    end

    bdlp_merge u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_fire              (w_fire),
        .i_ev                (w_ev),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_pressed_mask      (o_pressed_mask),
        .o_press_events      (o_press_events),
        .o_release_events    (o_release_events),
        .o_long_press_events (o_long_press_events)
    );

    // checks
    `BDLP_ASSERT(a_fire_gives_result, w_fire |=> o_out_valid, "accepted transaction has no result")
    `BDLP_ASSERT(a_sample_no_events, (w_fire && (w_cmd == CMD_SAMPLE)) |=> ((o_press_events | o_release_events | o_long_press_events) == '0), "events on a sample transaction")
    `BDLP_ASSERT(a_events_exclusive, o_out_valid |-> (((o_press_events & o_release_events) == '0) && (((o_press_events | o_release_events) & o_long_press_events) == '0)), "overlapping events on one button")
    `BDLP_ASSERT(a_events_match_mask, o_out_valid |-> (((o_press_events & ~o_pressed_mask) == '0) && ((o_release_events & o_pressed_mask) == '0) && ((o_long_press_events & ~o_pressed_mask) == '0)), "event disagrees with pressed mask")
    `BDLP_ASSERT_ANY(a_no_fire_in_reset, !i_rst_n |=> !w_fire, "transaction accepted right after reset")

endmodule
